/* hdl/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg
// Types, codes and helpers shared by the shell command tokenizer modules.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int MaxRes     = 4;
  localparam int CntW       = $clog2(MaxRes + 1);
  localparam int ResIdxW    = $clog2(MaxRes);
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChSQuote = 8'h27;
  localparam logic [7:0] ChDQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;

  localparam logic KindChar = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [2:0] {
    TYPE_WORD    = 3'd0,
    TYPE_OUT     = 3'd1,
    TYPE_OUT_APP = 3'd2,
    TYPE_ERR     = 3'd3,
    TYPE_ERR_APP = 3'd4,
    TYPE_EOL     = 3'd5
  } tok_type_t;

  typedef enum logic [3:0] {
    MODE_PLAIN    = 4'd0,
    MODE_SQ       = 4'd1,
    MODE_DQ       = 4'd2,
    MODE_ESC      = 4'd3,
    MODE_ESC_DQ   = 4'd4,
    MODE_COLLECT  = 4'd5,
    MODE_PEND_GT  = 4'd6,
    MODE_PEND_2   = 4'd7,
    MODE_PEND_2GT = 4'd8
  } mode_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] chr;
    logic [2:0] typ;
  } result_t;

  // All results caused by one input byte.
  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [CntW-1:0]      cnt;
  } bundle_t;

  function automatic bundle_t push_res(bundle_t b, logic kind, logic [7:0] chr,
                                       logic [2:0] typ);
    bundle_t r;
    r = b;
    if (b.cnt < CntW'(MaxRes)) begin
      r.res[b.cnt[ResIdxW-1:0]] = '{kind: kind, chr: chr, typ: typ};
      r.cnt = b.cnt + CntW'(1);
    end
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

/* hdl/sct_front.sv */
// ----------------------------------------------------------------------------
// sct_front
// Lexer state machine: classifies each byte and builds its result bundle.
// ----------------------------------------------------------------------------
module sct_front
  import sct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] character,
  input  logic       end_of_command,
  output bundle_t    bundle,
  output logic       bundle_valid
);

  mode_t      mode, mode_next;
  logic [2:0] ctype, ctype_next;
  logic       nonempty, nonempty_next;

  always_comb begin
    bundle_t    b;
    mode_t      m;
    logic [2:0] t;
    logic       ne;
    logic       run_plain;
    logic       run_collect;
    b           = '0;
    m           = mode;
    t           = ctype;
    ne          = nonempty;
    run_plain   = 1'b0;
    run_collect = 1'b0;

    unique case (mode)
      MODE_SQ: begin
        if (character == ChSQuote) begin
          m = MODE_PLAIN;
        end else begin
          b  = push_res(b, KindChar, character, TYPE_WORD);
          ne = 1'b1;
        end
      end
      MODE_DQ: begin
        if (character == ChDQuote) begin
          m = MODE_PLAIN;
        end else if (character == ChBslash) begin
          m = MODE_ESC_DQ;
        end else begin
          b  = push_res(b, KindChar, character, TYPE_WORD);
          ne = 1'b1;
        end
      end
      MODE_ESC: begin
        b  = push_res(b, KindChar, character, TYPE_WORD);
        ne = 1'b1;
        m  = MODE_PLAIN;
      end
      MODE_ESC_DQ: begin
        if (character != ChDQuote && character != ChBslash) begin
          b = push_res(b, KindChar, ChBslash, TYPE_WORD);
        end
        b  = push_res(b, KindChar, character, TYPE_WORD);
        ne = 1'b1;
        m  = MODE_DQ;
      end
      MODE_COLLECT: begin
        run_collect = 1'b1;
      end
      MODE_PEND_GT: begin
        m = MODE_COLLECT;
        if (character == ChGt) begin
          t = TYPE_OUT_APP;
        end else begin
          t           = TYPE_OUT;
          run_collect = 1'b1;
        end
      end
      MODE_PEND_2: begin
        if (character == ChGt) begin
          m = MODE_PEND_2GT;
        end else begin
          b         = push_res(b, KindChar, ChTwo, TYPE_WORD);
          ne        = 1'b1;
          m         = MODE_PLAIN;
          run_plain = 1'b1;
        end
      end
      MODE_PEND_2GT: begin
        m = MODE_COLLECT;
        if (character == ChGt) begin
          t = TYPE_ERR_APP;
        end else begin
          t           = TYPE_ERR;
          run_collect = 1'b1;
        end
      end
      default: begin
        m         = MODE_PLAIN;
        run_plain = 1'b1;
      end
    endcase

    if (run_plain) begin
      priority if (is_space(character)) begin
        if (ne) begin
          b  = push_res(b, KindEnd, 8'h00, t);
          ne = 1'b0;
          t  = TYPE_WORD;
        end
      end else if (character == ChSQuote) begin
        m = MODE_SQ;
      end else if (character == ChDQuote) begin
        m = MODE_DQ;
      end else if (character == ChBslash) begin
        m = MODE_ESC;
      end else if (character == ChGt) begin
        m = MODE_PEND_GT;
      end else if (character == ChTwo && !end_of_command) begin
        m = MODE_PEND_2;
      end else begin
        b  = push_res(b, KindChar, character, TYPE_WORD);
        ne = 1'b1;
      end
    end

    if (run_collect) begin
      if (is_space(character)) begin
        if (ne) begin
          b  = push_res(b, KindEnd, 8'h00, t);
          ne = 1'b0;
          t  = TYPE_WORD;
        end
        m = MODE_PLAIN;
      end else begin
        b  = push_res(b, KindChar, character, TYPE_WORD);
        ne = 1'b1;
      end
    end

    if (end_of_command) begin
      priority if (m == MODE_PEND_GT) begin
        t = TYPE_OUT;
      end else if (m == MODE_PEND_2GT) begin
        t = TYPE_ERR;
      end else if (m == MODE_PEND_2) begin
        b  = push_res(b, KindChar, ChTwo, TYPE_WORD);
        ne = 1'b1;
      end else begin
      end
      if (ne) begin
        b = push_res(b, KindEnd, 8'h00, t);
      end
      b  = push_res(b, KindEnd, 8'h00, TYPE_EOL);
      m  = MODE_PLAIN;
      t  = TYPE_WORD;
      ne = 1'b0;
    end

    bundle        = b;
    mode_next     = m;
    ctype_next    = t;
    nonempty_next = ne;
  end

  assign bundle_valid = accept && (bundle.cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_PLAIN;
      ctype    <= TYPE_WORD;
      nonempty <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      ctype    <= ctype_next;
      nonempty <= nonempty_next;
    end
  end

endmodule

/* hdl/sct_queue.sv */
// ----------------------------------------------------------------------------
// sct_queue
// Short bundle queue between the lexer and the result serializer.
// ----------------------------------------------------------------------------
module sct_queue
  import sct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  bundle_t wr_data,
  input  logic    rd,
  output bundle_t rd_data,
  output logic    full,
  output logic    empty
);

  bundle_t           slots [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == QCntW'(QueueDepth));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + QCntW'(1);
        2'b01:   count <= count - QCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/sct_back.sv */
// ----------------------------------------------------------------------------
// sct_back
// Result serializer: walks the head bundle one result per transfer.
// ----------------------------------------------------------------------------
module sct_back
  import sct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  bundle_t    head,
  input  logic       head_empty,
  output logic       head_pop,
  input  logic       pop,
  output logic       empty,
  output logic       result_kind,
  output logic [7:0] token_char,
  output logic [2:0] token_type,
  output logic       last_result
);

  logic [ResIdxW-1:0] idx;
  result_t            cur;
  logic               is_last;
  logic               xfer;

  assign cur         = head.res[idx];
  assign is_last     = ((CntW'(idx) + CntW'(1)) == head.cnt);
  assign empty       = head_empty;
  assign xfer        = pop && !head_empty;
  assign head_pop    = xfer && is_last;
  assign result_kind = cur.kind;
  assign token_char  = cur.chr;
  assign token_type  = cur.typ;
  assign last_result = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= is_last ? '0 : idx + ResIdxW'(1);
    end
  end

endmodule

/* hdl/shell_command_tokenizer.sv */
// ----------------------------------------------------------------------------
// shell_command_tokenizer
// Splits a command line into shell words, quotes, escapes and redirects.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | character, end_of_command
//  result   | pop / empty        | result_kind, token_char, token_type,
//           |                    | last_result
//
//  One byte is taken per cycle while full is low; the lexer state updates in that cycle.
//  Each byte yields 0 to 4 results, moved one per cycle by the serializer while pop is high.
//  A four-bundle queue between lexer and serializer sets how long a burst
//  of multi-result bytes is absorbed before full rises.
//  Synchronous reset clears lexer state and the queue; empty is high after it.
//  A byte's results reach the ports once its bundle is written into the queue.
module shell_command_tokenizer
  import sct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] character,
  input  logic       end_of_command,
  output logic       empty,
  input  logic       pop,
  output logic       result_kind,
  output logic [7:0] token_char,
  output logic [2:0] token_type,
  output logic       last_result
);

  bundle_t fr_bundle;
  logic    fr_valid;
  bundle_t q_head;
  logic    q_empty;
  logic    q_pop;
  logic    accept;

  assign accept = push && !full;

  sct_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .character      (character),
    .end_of_command (end_of_command),
    .bundle         (fr_bundle),
    .bundle_valid   (fr_valid)
  );

  sct_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (fr_valid),
    .wr_data (fr_bundle),
    .rd      (q_pop),
    .rd_data (q_head),
    .full    (full),
    .empty   (q_empty)
  );

  sct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .head_empty  (q_empty),
    .head_pop    (q_pop),
    .pop         (pop),
    .empty       (empty),
    .result_kind (result_kind),
    .token_char  (token_char),
    .token_type  (token_type),
    .last_result (last_result)
  );

endmodule

/* hdl/sct_checker.sv */
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks for the shell command tokenizer.
// ----------------------------------------------------------------------------
module sct_checker
  import sct_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       empty,
  input logic       pop,
  input logic       result_kind,
  input logic [7:0] token_char,
  input logic [2:0] token_type,
  input logic       last_result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results present after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (empty && !push) |=> empty)
    else $error("result appeared without an input transfer");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result_kind) && $stable(token_char)
                          && $stable(token_type) && $stable(last_result)))
    else $error("stalled result changed");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((result_kind == KindChar && token_type == TYPE_WORD) ||
                (result_kind == KindEnd && token_char == 8'h00)))
    else $error("inconsistent result fields");

  a_eol_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result_kind == KindEnd && token_type == TYPE_EOL) |-> last_result)
    else $error("end-of-line token is not the last result");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .empty       (empty),
  .pop         (pop),
  .result_kind (result_kind),
  .token_char  (token_char),
  .token_type  (token_type),
  .last_result (last_result)
);

/* bench/tb_shell_command_tokenizer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shell_command_tokenizer
// Streams command lines through the tokenizer and checks every result
// against typed table results, or a behavioral lexer kept in step with each
// accepted byte. A short table covers quoting, escapes, redirects and
// end-of-command cases; random lines follow with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_shell_command_tokenizer
  import sct_pkg::*;
();

  typedef struct packed {
    logic       kind;
    logic [7:0] chr;
    logic [2:0] typ;
    logic       last;
  } tok_res_t;

  typedef struct {
    logic [7:0] ch;
    logic       eoc;
    int         nk;
    tok_res_t   r0, r1, r2;
  } dir_row_t;

  localparam int DirRows = 28;
  localparam int RandItems = 450;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] character;
  logic       end_of_command;
  logic       empty;
  logic       pop;
  logic       result_kind;
  logic [7:0] token_char;
  logic [2:0] token_type;
  logic       last_result;

  shell_command_tokenizer dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .character(character), .end_of_command(end_of_command),
    .empty(empty), .pop(pop), .result_kind(result_kind),
    .token_char(token_char), .token_type(token_type),
    .last_result(last_result)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // lexer state mirror
  mode_t     lx_mode;
  tok_type_t cur_type;
  logic      held;

  tok_res_t step_out[$];
  tok_res_t typed_q[$];
  tok_res_t tok_exp[$];
  dir_row_t dir_tab[DirRows];

  int  errors = 0;
  bit  calm = 1'b0;
  int  sent = 0;

  function automatic bit stall_now();
    return !calm && ($urandom_range(0, 99) < 18);
  endfunction

  function automatic tok_res_t c_res(logic [7:0] c, logic l);
    return '{kind: KindChar, chr: c, typ: TYPE_WORD, last: l};
  endfunction

  function automatic tok_res_t e_res(tok_type_t t, logic l);
    return '{kind: KindEnd, chr: 8'h00, typ: t, last: l};
  endfunction

  function automatic bit blank(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void add_out(logic k, logic [7:0] c, logic [2:0] t);
    if (step_out.size() < MaxRes)
      step_out.insert(step_out.size(), tok_res_t'{kind: k, chr: c, typ: t, last: 1'b0});
  endfunction

  function automatic void add_chr(logic [7:0] c);
    add_out(KindChar, c, TYPE_WORD);
    held = 1'b1;
  endfunction

  function automatic void close_tok();
    add_out(KindEnd, 8'h00, cur_type);
    held = 1'b0;
    cur_type = TYPE_WORD;
  endfunction

  function automatic void lex_reset();
    lx_mode = MODE_PLAIN;
    cur_type = TYPE_WORD;
    held = 1'b0;
  endfunction

  function automatic void plain_byte(logic [7:0] c, logic l);
    if (blank(c)) begin
      if (held) close_tok();
    end else if (c == ChSQuote) begin
      lx_mode = MODE_SQ;
    end else if (c == ChDQuote) begin
      lx_mode = MODE_DQ;
    end else if (c == ChBslash) begin
      lx_mode = MODE_ESC;
    end else if (c == ChGt) begin
      lx_mode = MODE_PEND_GT;
    end else if (c == ChTwo && !l) begin
      lx_mode = MODE_PEND_2;
    end else begin
      add_chr(c);
    end
  endfunction

  function automatic void collect_byte(logic [7:0] c);
    if (blank(c)) begin
      if (held) close_tok();
      lx_mode = MODE_PLAIN;
    end else begin
      add_chr(c);
    end
  endfunction

  // results for one accepted byte land in step_out
  function automatic void lex_byte(logic [7:0] c, logic l);
    step_out.delete();
    case (lx_mode)
      MODE_SQ: begin
        if (c == ChSQuote) lx_mode = MODE_PLAIN;
        else add_chr(c);
      end
      MODE_DQ: begin
        if (c == ChDQuote) lx_mode = MODE_PLAIN;
        else if (c == ChBslash) lx_mode = MODE_ESC_DQ;
        else add_chr(c);
      end
      MODE_ESC: begin
        add_chr(c);
        lx_mode = MODE_PLAIN;
      end
      MODE_ESC_DQ: begin
        if (c != ChDQuote && c != ChBslash) add_chr(ChBslash);
        add_chr(c);
        lx_mode = MODE_DQ;
      end
      MODE_COLLECT: collect_byte(c);
      MODE_PEND_GT: begin
        lx_mode = MODE_COLLECT;
        if (c == ChGt) begin
          cur_type = TYPE_OUT_APP;
        end else begin
          cur_type = TYPE_OUT;
          collect_byte(c);
        end
      end
      MODE_PEND_2: begin
        if (c == ChGt) begin
          lx_mode = MODE_PEND_2GT;
        end else begin
          add_chr(ChTwo);
          lx_mode = MODE_PLAIN;
          plain_byte(c, l);
        end
      end
      MODE_PEND_2GT: begin
        lx_mode = MODE_COLLECT;
        if (c == ChGt) begin
          cur_type = TYPE_ERR_APP;
        end else begin
          cur_type = TYPE_ERR;
          collect_byte(c);
        end
      end
      default: begin
        lx_mode = MODE_PLAIN;
        plain_byte(c, l);
      end
    endcase
    if (l) begin
      if (lx_mode == MODE_PEND_GT) cur_type = TYPE_OUT;
      else if (lx_mode == MODE_PEND_2GT) cur_type = TYPE_ERR;
      else if (lx_mode == MODE_PEND_2) add_chr(ChTwo);
      if (held) close_tok();
      cur_type = TYPE_EOL;
      close_tok();
      lex_reset();
    end
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] c, input logic e);
    while (stall_now()) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    character <= c;
    end_of_command <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    lex_byte(c, e);
    if (typed_q.size() > 0) begin
      foreach (typed_q[i]) tok_exp.insert(tok_exp.size(), typed_q[i]);
      typed_q.delete();
    end else begin
      foreach (step_out[i]) tok_exp.insert(tok_exp.size(), step_out[i]);
    end
    sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 45) begin
      r = $urandom_range(8, 13);
      return (r == 8) ? 8'h20 : 8'(r);
    end
    if (r < 52) return ChSQuote;
    if (r < 60) return ChDQuote;
    if (r < 68) return ChBslash;
    if (r < 78) return ChGt;
    if (r < 86) return ChTwo;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int len;
    bit paused;
    rst = 1'b1;
    push = 1'b0;
    character = 8'h00;
    end_of_command = 1'b0;
    paused = 1'b0;
    lex_reset();
    dir_tab = '{
      '{8'h00, 1'b0, 1, c_res(8'h00, 1'b1), '0, '0},
      '{8'hFF, 1'b1, 3, c_res(8'hFF, 1'b0), e_res(TYPE_WORD, 1'b0), e_res(TYPE_EOL, 1'b1)},
      '{8'h20, 1'b1, 1, e_res(TYPE_EOL, 1'b1), '0, '0},
      '{ChTwo, 1'b1, 3, c_res(ChTwo, 1'b0), e_res(TYPE_WORD, 1'b0), e_res(TYPE_EOL, 1'b1)},
      '{ChGt,     1'b0, 0, '0, '0, '0},
      '{ChGt,     1'b0, 0, '0, '0, '0},
      '{8'h66,    1'b0, 0, '0, '0, '0},
      '{8'h09,    1'b0, 0, '0, '0, '0},
      '{ChTwo,    1'b0, 0, '0, '0, '0},
      '{ChGt,     1'b0, 0, '0, '0, '0},
      '{8'h65,    1'b0, 0, '0, '0, '0},
      '{8'h0D,    1'b0, 0, '0, '0, '0},
      '{ChTwo,    1'b0, 0, '0, '0, '0},
      '{8'h61,    1'b0, 0, '0, '0, '0},
      '{ChTwo,    1'b0, 0, '0, '0, '0},
      '{ChGt,     1'b1, 0, '0, '0, '0},
      '{ChSQuote, 1'b0, 0, '0, '0, '0},
      '{ChSQuote, 1'b0, 0, '0, '0, '0},
      '{ChDQuote, 1'b0, 0, '0, '0, '0},
      '{ChBslash, 1'b0, 0, '0, '0, '0},
      '{ChDQuote, 1'b0, 0, '0, '0, '0},
      '{ChBslash, 1'b0, 0, '0, '0, '0},
      '{8'h6E,    1'b0, 0, '0, '0, '0},
      '{ChBslash, 1'b0, 0, '0, '0, '0},
      '{ChBslash, 1'b0, 0, '0, '0, '0},
      '{8'h7A,    1'b1, 0, '0, '0, '0},
      '{ChBslash, 1'b0, 0, '0, '0, '0},
      '{ChGt,     1'b1, 0, '0, '0, '0}
    };
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].nk >= 1) typed_q.insert(typed_q.size(), dir_tab[i].r0);
      if (dir_tab[i].nk >= 2) typed_q.insert(typed_q.size(), dir_tab[i].r1);
      if (dir_tab[i].nk >= 3) typed_q.insert(typed_q.size(), dir_tab[i].r2);
      send_byte(dir_tab[i].ch, dir_tab[i].eoc);
    end

    sent = 0;
    while (sent < RandItems) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int k = 0; k < len; k++) send_byte(rand_char(), k == len - 1);
      calm = (sent >= 200 && sent < 300);
      if (!paused && sent >= 120) begin
        // drain everything before going on
        paused = 1'b1;
        push <= 1'b0;
        do @(negedge clk); while (tok_exp.size() != 0);
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (tok_exp.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("tb_shell_command_tokenizer OK");
    end else begin
      $display("tb_shell_command_tokenizer NOT OK");
    end
    $finish;
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin
    tok_res_t want;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= !stall_now();
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (tok_exp.size() == 0) begin
          errors++;
          $display("%0t: extra transfer, expected none, got kind %0b char %0h type %0d last %0b",
                   $time, result_kind, token_char, token_type, last_result);
        end else begin
          want = tok_exp.pop_front();
          check_field("result_kind", 8'(want.kind), 8'(result_kind));
          check_field("token_char", want.chr, token_char);
          check_field("token_type", 8'(want.typ), 8'(token_type));
          check_field("last_result", 8'(want.last), 8'(last_result));
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("tb_shell_command_tokenizer NOT OK");
    $finish;
  end

endmodule
